// ===== hdl/cpmt_pkg.sv =====
package cpmt_pkg;

  localparam int unsigned CHAR_KEY_W        = 32;
  localparam int unsigned POSITION_W        = 6;
  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned MAX_POSITIONS_DEF = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPARE,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESULT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch item, start search window
    logic srch_rd;    // read entry at mid
    logic srch_step;  // narrow the window from read data
    logic shift_rd;   // read entry below the shift pointer
    logic shift_wr;   // write it one slot up, step pointer down
    logic write_hit;  // OR position bit into found entry
    logic write_new;  // place new key, bump count
    logic out_load;   // move result into output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_done;
    logic is_query;
    logic found;
    logic full;
    logic shift_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/cpmt_ctrl.sv =====
module cpmt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cpmt_pkg::dp_status_t  status_i,
  output cpmt_pkg::ctrl_cmd_t   cmd_o
);

  cpmt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpmt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cpmt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = cpmt_pkg::ST_SEARCH;
        end
      end
      cpmt_pkg::ST_SEARCH: begin
        if (status_i.search_done) begin
          state_d = cpmt_pkg::ST_DECIDE;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = cpmt_pkg::ST_COMPARE;
        end
      end
      cpmt_pkg::ST_COMPARE: begin
        cmd_o.srch_step = 1'b1;
        state_d         = cpmt_pkg::ST_SEARCH;
      end
      cpmt_pkg::ST_DECIDE: begin
        if (status_i.is_query || status_i.full && !status_i.found) begin
          state_d = cpmt_pkg::ST_RESULT;
        end else if (status_i.found) begin
          cmd_o.write_hit = 1'b1;
          state_d         = cpmt_pkg::ST_RESULT;
        end else begin
          state_d = cpmt_pkg::ST_SHIFT_RD;
        end
      end
      cpmt_pkg::ST_SHIFT_RD: begin
        if (status_i.shift_done) begin
          cmd_o.write_new = 1'b1;
          state_d         = cpmt_pkg::ST_RESULT;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d        = cpmt_pkg::ST_SHIFT_WR;
        end
      end
      cpmt_pkg::ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = cpmt_pkg::ST_SHIFT_RD;
      end
      cpmt_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = cpmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cpmt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/cpmt_dp.sv =====
module cpmt_dp #(
  parameter int unsigned TABLE_ENTRIES = cpmt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_POSITIONS = cpmt_pkg::MAX_POSITIONS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cpmt_pkg::ctrl_cmd_t                 cmd_i,
  output cpmt_pkg::dp_status_t                status_o,
  input  logic                                command_i,
  input  logic [cpmt_pkg::CHAR_KEY_W-1:0]     char_key_i,
  input  logic [cpmt_pkg::POSITION_W-1:0]     position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                key_found_o,
  output logic                                position_hit_o,
  output logic                                table_full_o
);

  localparam int unsigned KW = cpmt_pkg::CHAR_KEY_W;
  localparam int unsigned MW = MAX_POSITIONS;
  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned DW = KW + MW;
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  // entry memory: {key, mask}
  logic [DW-1:0] mem [TABLE_ENTRIES];
  logic [DW-1:0] rdata_q;
  logic          mem_re, mem_we;
  logic [IW-1:0] raddr, waddr;
  logic [DW-1:0] wdata;

  logic          cmd_q;
  logic [KW-1:0] key_q;
  logic [cpmt_pkg::POSITION_W-1:0] pos_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, sp_q, sp_d, mid;
  logic          found_q, found_d, full_q, full_d;
  logic [MW-1:0] fmask_q, fmask_d;
  logic          out_valid_q, out_valid_d;
  logic          key_found_q, position_hit_q, table_full_q;

  logic [KW-1:0] rd_key;
  logic [MW-1:0] rd_mask, pos_bit;
  logic [CW-1:0] sp_m1;

  assign rd_key  = rdata_q[DW-1:MW];
  assign rd_mask = rdata_q[MW-1:0];
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign sp_m1   = sp_q - CW'(1);
  assign pos_bit = ({1'b0, pos_q} < 7'(MW)) ? (MW'(1) << pos_q) : '0;

  always_comb begin
    mem_re = cmd_i.srch_rd | cmd_i.shift_rd;
    raddr  = cmd_i.shift_rd ? sp_m1[IW-1:0] : mid[IW-1:0];
    mem_we = cmd_i.shift_wr | cmd_i.write_hit | cmd_i.write_new;
    waddr  = cmd_i.shift_wr ? sp_q[IW-1:0] : lo_q[IW-1:0];
    if (cmd_i.shift_wr) begin
      wdata = rdata_q;
    end else if (cmd_i.write_hit) begin
      wdata = {key_q, fmask_q | pos_bit};
    end else begin
      wdata = {key_q, pos_bit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // item payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      key_q <= char_key_i;
      pos_q <= position_i;
    end
  end

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    sp_d    = sp_q;
    found_d = found_q;
    fmask_d = fmask_q;
    full_d  = full_q;
    count_d = count_q;
    if (cmd_i.load) begin
      lo_d    = '0;
      hi_d    = count_q;
      sp_d    = count_q;
      found_d = 1'b0;
      full_d  = (count_q == FULL_COUNT);
    end
    if (cmd_i.srch_step) begin
      if (rd_key < key_q) begin
        lo_d = mid + CW'(1);
      end else begin
        hi_d = mid;
      end
      if (rd_key == key_q) begin
        found_d = 1'b1;
        fmask_d = rd_mask;
      end
    end
    if (cmd_i.shift_wr) begin
      sp_d = sp_m1;
    end
    if (cmd_i.write_new) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q    <= '0;
      hi_q    <= '0;
      sp_q    <= '0;
      found_q <= 1'b0;
      full_q  <= 1'b0;
      count_q <= '0;
    end else begin
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      sp_q    <= sp_d;
      found_q <= found_d;
      full_q  <= full_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fmask_q <= fmask_d;
  end

  // output register
  assign out_valid_d = cmd_i.out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      key_found_q    <= found_q;
      position_hit_q <= (cmd_q == cpmt_pkg::CMD_QUERY) & found_q & (|(fmask_q & pos_bit));
      table_full_q   <= (cmd_q == cpmt_pkg::CMD_INSERT) & ~found_q & full_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_found_o    = key_found_q;
  assign position_hit_o = position_hit_q;
  assign table_full_o   = table_full_q;

  assign status_o.search_done = (lo_q == hi_q);
  assign status_o.is_query    = (cmd_q == cpmt_pkg::CMD_QUERY);
  assign status_o.found       = found_q;
  assign status_o.full        = full_q;
  assign status_o.shift_done  = (sp_q == lo_q);
  assign status_o.out_free    = ~out_valid_q | out_ready_i;

endmodule

// ===== hdl/char_position_mask_table.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o   command_i, char_key_i, position_i
// out      output     out_valid_o / out_ready_i key_found_o, position_hit_o, table_full_o
//
// One item at a time: the time from accept to result for n stored keys is set by the binary
// search (registered memory read, compare next cycle). A new key adds one read and one write
// for each of the entries moved up one slot; the next item can be taken in the cycle after
// the result is loaded.
// Reset empties the table at once (entry count to zero); no clearing pass.
// A held result does not block accept or search; only the final hand-off waits on out_ready_i.
module char_position_mask_table #(
  parameter int unsigned TABLE_ENTRIES = cpmt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned MAX_POSITIONS = cpmt_pkg::MAX_POSITIONS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            command_i,
  input  logic [cpmt_pkg::CHAR_KEY_W-1:0] char_key_i,
  input  logic [cpmt_pkg::POSITION_W-1:0] position_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            key_found_o,
  output logic                            position_hit_o,
  output logic                            table_full_o
);

  // command and status between sequencer and datapath
  cpmt_pkg::ctrl_cmd_t  cmd;
  cpmt_pkg::dp_status_t status;

  // sequencer: search, decide, shift-up, write, hand off result
  cpmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: entry memory, search window, entry count, output register
  cpmt_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .command_i      (command_i),
    .char_key_i     (char_key_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_found_o    (key_found_o),
    .position_hit_o (position_hit_o),
    .table_full_o   (table_full_o)
  );

endmodule

// ===== verif/char_position_mask_table_chk.sv =====
`timescale 1ns / 1ps

// Watches both channels, keeps its own sorted key table and checks each result item.
module char_position_mask_table_chk (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            command_i,
  input  logic [cpmt_pkg::CHAR_KEY_W-1:0] char_key_i,
  input  logic [cpmt_pkg::POSITION_W-1:0] position_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic                            key_found_i,
  input  logic                            position_hit_i,
  input  logic                            table_full_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  localparam int TABLE_DEPTH = cpmt_pkg::TABLE_ENTRIES_DEF;
  localparam int MAX_POS     = cpmt_pkg::MAX_POSITIONS_DEF;

  typedef struct packed {
    logic found;
    logic hit;
    logic full;
  } lookup_result_t;

  bit [31:0]      key_tbl  [TABLE_DEPTH];
  bit [31:0]      mask_tbl [TABLE_DEPTH];
  int             key_count;
  lookup_result_t lookup_q [$];
  int             mismatches = 0;
  int             result_idx = 0;

  task automatic report_mismatch(input string what, input logic got, input logic want);
    if (mismatches < 20)
      $display("%0t ns: result %0d: %s is %b, expected %b", $time, result_idx, what, got,
               want);
    mismatches++;
  endtask

  // Applies one item to the local table and returns what the block must answer.
  function automatic lookup_result_t apply_item(input logic cmd, input logic [31:0] key,
                                                input logic [5:0] pos);
    lookup_result_t r;
    int             slot;
    int             j;
    bit [31:0]      pos_mask;
    r        = '0;
    slot     = 0;
    pos_mask = (pos < MAX_POS) ? (32'd1 << pos) : 32'd0;
    // first slot whose key is not below the item's key
    while (slot < key_count && key_tbl[slot] < key) slot++;
    r.found = (slot < key_count) && (key_tbl[slot] == key);
    if (cmd == cpmt_pkg::CMD_QUERY) begin
      if (r.found) r.hit = |(mask_tbl[slot] & pos_mask);
    end else if (r.found) begin
      mask_tbl[slot] |= pos_mask;
    end else if (key_count >= TABLE_DEPTH) begin
      r.full = 1'b1;
    end else begin
      for (j = key_count; j > slot; j--) begin
        key_tbl[j]  = key_tbl[j-1];
        mask_tbl[j] = mask_tbl[j-1];
      end
      key_tbl[slot]  = key;
      mask_tbl[slot] = pos_mask;
      key_count++;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      key_count = 0;
      lookup_q.delete();
      pending_o <= 0;
    end else begin
      // a result always belongs to an item taken on an earlier edge
      if (out_valid_i && out_ready_i) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("result with none outstanding, key_found", key_found_i, 1'b0);
        end else begin
          want = lookup_q.pop_front();
          if (key_found_i !== want.found)
            report_mismatch("key_found", key_found_i, want.found);
          if (position_hit_i !== want.hit)
            report_mismatch("position_hit", position_hit_i, want.hit);
          if (table_full_i !== want.full)
            report_mismatch("table_full", table_full_i, want.full);
        end
        result_idx++;
      end
      if (in_valid_i && in_ready_i)
        lookup_q.push_back(apply_item(command_i, char_key_i, position_i));
      pending_o <= lookup_q.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

// ===== verif/tb_char_position_mask_table.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the sorted character table. Checking lives in
// char_position_mask_table_chk, which sits beside the block on the same wires.
module tb_char_position_mask_table;

  // cycles with no item moving on either channel before the run is called hung;
  // the worst item is a full search plus a shift of up to 255 entries
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 150;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            in_valid_i     = 1'b0;
  logic                            in_ready_o;
  logic                            command_i      = cpmt_pkg::CMD_INSERT;
  logic [cpmt_pkg::CHAR_KEY_W-1:0] char_key_i     = '0;
  logic [cpmt_pkg::POSITION_W-1:0] position_i     = '0;
  logic                            out_valid_o;
  logic                            out_ready_i    = 1'b0;
  logic                            key_found_o;
  logic                            position_hit_o;
  logic                            table_full_o;

  int fail_count;
  int pending_cnt;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int idle_cycles  = 0;

  // every key ever sent in an insert; pool for repeat inserts and queries
  logic [31:0] sent_keys [$];
  bit          key_seen  [logic [31:0]];

  char_position_mask_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .char_key_i     (char_key_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_found_o    (key_found_o),
    .position_hit_o (position_hit_o),
    .table_full_o   (table_full_o)
  );

  char_position_mask_table_chk u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .char_key_i     (char_key_i),
    .position_i     (position_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_found_i    (key_found_o),
    .position_hit_i (position_hit_o),
    .table_full_i   (table_full_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_cnt)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Receiver back-pressure, redrawn every cycle at the current stall rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Hang detector: any accepted item on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("char_position_mask_table test failed");
      $finish;
    end
  end

  // Offer one item; valid stays up with a steady payload until taken.
  // Idle cycles in front of it are drawn per cycle at the sender's idle rate.
  task automatic push_item(input logic cmd, input logic [31:0] key, input logic [5:0] pos);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    char_key_i <= key;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == cpmt_pkg::CMD_INSERT && !key_seen.exists(key)) begin
      key_seen[key] = 1'b1;
      sent_keys.push_back(key);
    end
  endtask

  // Hold the sender off until every outstanding result item is back. The extra
  // edge lets the checker's count take in the item accepted just now.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // A UTF-8-shaped key: one to four random bytes, left aligned, zero padded.
  function automatic logic [31:0] utf8_key();
    int          nbytes;
    logic [31:0] raw;
    nbytes = $urandom_range(1, 4);
    raw    = $urandom;
    return raw & ~(32'hFFFF_FFFF >> (8 * nbytes));
  endfunction

  function automatic logic [31:0] known_key();
    return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
  endfunction

  // Random item. New keys dominate until the table has overflowed, so the
  // later part runs against a full table: dropped inserts, repeat inserts
  // into full table, and queries of both stored and dropped keys.
  task automatic send_random();
    int          roll;
    int          fresh_pct;
    logic        cmd;
    logic [31:0] key;
    logic [5:0]  pos;
    roll      = $urandom_range(0, 99);
    fresh_pct = (sent_keys.size() < 270) ? 60 : 25;
    // mostly in-range positions so hits are common; the rest ignored ones
    pos = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 31)) : 6'($urandom_range(32, 63));
    if (roll < fresh_pct) begin
      cmd = cpmt_pkg::CMD_INSERT;
      do key = utf8_key(); while (key_seen.exists(key));
    end else if (roll < fresh_pct + 15) begin
      cmd = cpmt_pkg::CMD_INSERT;
      key = known_key();
    end else begin
      cmd = cpmt_pkg::CMD_QUERY;
      key = ($urandom_range(0, 2) != 0) ? known_key() : utf8_key();
    end
    push_item(cmd, key, pos);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty table, key extremes, ignored positions, sorted placement.
    push_item(cpmt_pkg::CMD_QUERY,  32'h0000_0000, 6'd0);   // empty table lookup
    push_item(cpmt_pkg::CMD_INSERT, 32'h0000_0000, 6'd0);   // zero key is a normal key
    push_item(cpmt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd31);  // top key, top position
    push_item(cpmt_pkg::CMD_INSERT, 32'h4100_0000, 6'd5);
    push_item(cpmt_pkg::CMD_INSERT, 32'hE4B8_AD00, 6'd32);  // new key, empty mask
    push_item(cpmt_pkg::CMD_INSERT, 32'hF09F_9880, 6'd63);
    push_item(cpmt_pkg::CMD_INSERT, 32'h4100_0000, 6'd31);  // existing key, OR in a bit
    push_item(cpmt_pkg::CMD_INSERT, 32'h4100_0000, 6'd40);  // existing key, ignored position
    push_item(cpmt_pkg::CMD_INSERT, 32'h8000_0000, 6'd16);  // lands mid table
    push_item(cpmt_pkg::CMD_INSERT, 32'h0000_0001, 6'd1);   // shifts nearly all entries
    push_item(cpmt_pkg::CMD_QUERY,  32'h0000_0000, 6'd0);
    push_item(cpmt_pkg::CMD_QUERY,  32'hFFFF_FFFF, 6'd31);
    push_item(cpmt_pkg::CMD_QUERY,  32'hFFFF_FFFF, 6'd30);
    push_item(cpmt_pkg::CMD_QUERY,  32'hE4B8_AD00, 6'd32);  // found, position ignored
    push_item(cpmt_pkg::CMD_QUERY,  32'hE4B8_AD00, 6'd0);
    push_item(cpmt_pkg::CMD_QUERY,  32'h4100_0000, 6'd5);
    push_item(cpmt_pkg::CMD_QUERY,  32'h4100_0000, 6'd31);
    push_item(cpmt_pkg::CMD_QUERY,  32'h4100_0000, 6'd63);
    push_item(cpmt_pkg::CMD_QUERY,  32'h4200_0000, 6'd5);   // absent key
    push_item(cpmt_pkg::CMD_QUERY,  32'hF09F_9880, 6'd63);
    push_item(cpmt_pkg::CMD_QUERY,  32'h8000_0000, 6'd16);
    push_item(cpmt_pkg::CMD_QUERY,  32'h0000_0001, 6'd1);
    drain_results();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct   = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct   = 63;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct   = 0;
          rx_stall_pct <= 63;
        end
        default: begin
          tx_idle_pct   = 17;
          rx_stall_pct <= 17;
        end
      endcase
      repeat (PHASE_ITEMS) send_random();
      if (phase == 1) drain_results();
    end

    drain_results();
    repeat (600) @(posedge clk_i);
    if (fail_count == 0)
      $display("char_position_mask_table test passed");
    else
      $display("char_position_mask_table test failed");
    $finish;
  end

endmodule
